>>> src/mhb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap builder package
// Shared sizes, beat types and the compare-unit result type.
// ----------------------------------------------------------------------------
package mhb_pkg;

	localparam int HEAP_DEPTH = 64;
	localparam int KEY_W      = 32;
	localparam int IDX_W      = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		key_t key;
		logic last;
	} in_beat_t;

	typedef struct packed {
		key_t key_res;
		logic last_res;
		logic overflow;
	} out_beat_t;

	// Outcome of one sift step: which child, if any, moves up.
	typedef struct packed {
		logic take_left;
		logic take_right;
	} cmp_sel_t;

endpackage

>>> src/mhb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap key store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module mhb_store (
	input  logic                      clk,
	input  logic                      we,
	input  logic [mhb_pkg::IDX_W-1:0] waddr,
	input  mhb_pkg::key_t             wdata,
	input  logic [mhb_pkg::IDX_W-1:0] raddr,
	output mhb_pkg::key_t             rdata
);
	import mhb_pkg::*;

	key_t mem_q [HEAP_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/mhb_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sift compare unit
// Picks the larger child against the held key, left child on a tie.
// ----------------------------------------------------------------------------
module mhb_cmp (
	input  mhb_pkg::key_t    key,
	input  mhb_pkg::key_t    left,
	input  mhb_pkg::key_t    right,
	input  logic             left_ok,
	input  logic             right_ok,
	output mhb_pkg::cmp_sel_t sel
);
	import mhb_pkg::*;

	logic left_win;
	key_t best;
	logic right_win;

	always_comb begin
		left_win       = left_ok && (left > key);
		best           = left_win ? left : key;
		right_win      = right_ok && (right > best);
		sel.take_right = right_win;
		sel.take_left  = left_win && !right_win;
	end

endmodule

>>> src/max_heap_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap builder
// Loads a set of signed keys, heapifies them bottom-up and streams the heap.
// ----------------------------------------------------------------------------
// A key beat is taken at any rising edge where start is high and busy is low.
// The beat flagged last closes the set and the block raises busy while it
// builds the heap and streams it out. The build runs every node from n/2 down
// to the root through one compare unit and the single read and single write
// port of the key store: the fetch, take, left and right states open a node
// and test it against its children, the left and right states come again for
// each level the key sinks onto a node that still has children, and the place
// state writes the key when it sinks into a leaf. The results then follow on
// consecutive cycles, root first, one beat per cycle, each shown for exactly
// one cycle under strobe; the receiver cannot stall them, so it must take a
// beat on every strobe. The final beat carries last_res, and every beat of a
// set that lost keys to a full store carries overflow. busy falls in the cycle
// the last result is shown, so the next set may start loading right away.
// ----------------------------------------------------------------------------
module max_heap_builder_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mhb_pkg::in_beat_t key_item,
	output logic              strobe,
	output mhb_pkg::out_beat_t heap_item
);
	import mhb_pkg::*;

	// Sequencer states.
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FETCH = 7'b0000010,
		S_TAKE  = 7'b0000100,
		S_LEFT  = 7'b0001000,
		S_RIGHT = 7'b0010000,
		S_PLACE = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;     // keys held, later the heap size n
	logic                   ovf_q;       // a key was dropped in this set
	logic [CNT_W-2:0]       node_q;      // node being sifted, n/2 down to 1
	logic [CNT_W-1:0]       pos_q;       // current position of the sinking key
	key_t                   key_q;       // key being sifted
	key_t                   left_q;      // left child of pos_q
	logic [IDX_W-1:0]       emit_q;      // next store index to stream out

	logic                   strobe_s1;
	logic                   last_s1;
	logic                   ovf_s1;

	logic                   we;
	logic [IDX_W-1:0]       waddr;
	key_t                   wdata;
	logic [IDX_W-1:0]       raddr;
	key_t                   rdata;

	logic [CNT_W:0]         lpos;        // left child position of pos_q
	logic [CNT_W:0]         rpos;        // right child position of pos_q
	logic                   left_ok;
	logic                   right_ok;
	cmp_sel_t               sel;
	logic [CNT_W:0]         child_pos;
	logic [CNT_W:0]         child_lpos;  // left child of the chosen child
	logic                   child_has_kids;
	logic                   full;
	logic [CNT_W-1:0]       n_next;      // set size once this key is counted
	logic                   emit_last;

	mhb_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// In the right-child state the store read data is the right child.
	mhb_cmp u_cmp (
		.key      (key_q),
		.left     (left_q),
		.right    (rdata),
		.left_ok  (left_ok),
		.right_ok (right_ok),
		.sel      (sel)
	);

	always_comb begin
		lpos           = {pos_q, 1'b0};
		rpos           = {pos_q, 1'b1};
		left_ok        = lpos <= {1'b0, count_q};
		right_ok       = rpos <= {1'b0, count_q};
		child_pos      = sel.take_right ? rpos : lpos;
		child_lpos     = {child_pos[CNT_W-1:0], 1'b0};
		child_has_kids = child_lpos <= {1'b0, count_q};
		full           = count_q == CNT_W'(HEAP_DEPTH);
		n_next         = full ? count_q : CNT_W'(count_q + 1'b1);
		emit_last      = {1'b0, emit_q} == CNT_W'(count_q - 1'b1);
	end

	// Store port steering. Reads issued here return data in the next state.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = key_q;
		raddr = '0;
		case (state_q)
			S_IDLE: begin
				we    = start && !full;
				waddr = count_q[IDX_W-1:0];
				wdata = key_item.key;
			end
			S_FETCH: begin
				raddr = IDX_W'(node_q - 1'b1);
			end
			S_TAKE: begin
				raddr = IDX_W'(lpos - 1'b1);
			end
			S_LEFT: begin
				// With no right child the index points past the heap or wraps; the data is ignored.
				raddr = IDX_W'(rpos - 1'b1);
			end
			S_RIGHT: begin
				we    = 1'b1;
				waddr = IDX_W'(pos_q - 1'b1);
				if (sel.take_left) begin
					wdata = left_q;
				end else if (sel.take_right) begin
					wdata = rdata;
				end
				raddr = IDX_W'(child_lpos - 1'b1);
			end
			S_PLACE: begin
				we    = 1'b1;
				waddr = IDX_W'(pos_q - 1'b1);
			end
			S_EMIT: begin
				raddr = emit_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Sequencer. The sinking key stays in key_q; each step moves the larger
	// child up into the hole, and the key is written once where it settles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			node_q    <= '0;
			emit_q    <= '0;
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					emit_q <= '0;
					if (start) begin
						count_q <= n_next;
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (key_item.last) begin
							node_q <= n_next[CNT_W-1:1];
							if (n_next[CNT_W-1:1] == '0) begin
								state_q <= S_EMIT;
							end else begin
								state_q <= S_FETCH;
							end
						end
					end
				end
				S_FETCH: begin
					state_q <= S_TAKE;
				end
				S_TAKE: begin
					state_q <= S_LEFT;
				end
				S_LEFT: begin
					state_q <= S_RIGHT;
				end
				S_RIGHT: begin
					if (sel.take_left || sel.take_right) begin
						state_q <= child_has_kids ? S_LEFT : S_PLACE;
					end else if (node_q == (CNT_W-1)'(1)) begin
						state_q <= S_EMIT;
					end else begin
						node_q  <= node_q - 1'b1;
						state_q <= S_FETCH;
					end
				end
				S_PLACE: begin
					if (node_q == (CNT_W-1)'(1)) begin
						state_q <= S_EMIT;
					end else begin
						node_q  <= node_q - 1'b1;
						state_q <= S_FETCH;
					end
				end
				S_EMIT: begin
					strobe_s1 <= 1'b1;
					emit_q    <= emit_q + 1'b1;
					if (emit_last) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_FETCH: begin
				pos_q <= {1'b0, node_q};
			end
			S_TAKE: begin
				key_q <= rdata;
			end
			S_LEFT: begin
				left_q <= rdata;
			end
			S_RIGHT: begin
				if (sel.take_left || sel.take_right) begin
					pos_q <= child_pos[CNT_W-1:0];
				end
			end
			S_EMIT: begin
				last_s1 <= emit_last;
				ovf_s1  <= ovf_q;
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign busy               = state_q != S_IDLE;
	assign strobe             = strobe_s1;
	assign heap_item.key_res  = rdata;
	assign heap_item.last_res = last_s1;
	assign heap_item.overflow = ovf_s1;

	// A result beat only follows a cycle spent streaming.
	a_strobe_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == S_EMIT))
		else $error("result beat without a streaming cycle");

	// The last result of a set is never followed by another beat at once.
	a_last_ends_set: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && heap_item.last_res) |=> !strobe)
		else $error("result beat right after the final one");

	// The store never counts more keys than it can hold.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HEAP_DEPTH))
		else $error("key count beyond store depth");

	// While sifting, the key sits inside the heap and has a left child to read.
	a_sift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEFT || state_q == S_RIGHT) |-> (pos_q != '0 && left_ok))
		else $error("sift position outside the heap");

	// Loading ends the moment the final key arrives.
	a_last_starts_build: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && key_item.last) |=> busy)
		else $error("final key did not start the build");

endmodule

>>> bench/heap_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap order checker
// Mirrors each key set in a shadow store and, when the set closes, builds the
// max-heap itself and checks every result beat against it in order.
// ----------------------------------------------------------------------------
module heap_order_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  mhb_pkg::in_beat_t  key_item,
	input  logic               strobe,
	input  mhb_pkg::out_beat_t heap_item,
	output int                 mismatches,
	output int                 heap_beats_due
);
	import mhb_pkg::*;

	localparam int PRINT_CAP = 40;

	key_t      shadow_keys [HEAP_DEPTH];
	int        keys_held;
	logic      keys_dropped;
	out_beat_t heap_due_q [$];

	int        node;
	int        pos;
	int        big;
	logic      settled;
	key_t      swap_key;
	out_beat_t want;

	initial mismatches = 0;
	assign heap_beats_due = heap_due_q.size();

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("%0t ns: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_held    = 0;
			keys_dropped = 1'b0;
			heap_due_q.delete();
		end else begin
			if (strobe) begin
				if (heap_due_q.size() == 0) begin
					report_mismatch($sformatf("result beat key %0d with none expected",
						heap_item.key_res));
				end else begin
					want = heap_due_q.pop_front();
					if (heap_item.key_res !== want.key_res)
						report_mismatch($sformatf("key_res %0d, expected %0d",
							heap_item.key_res, want.key_res));
					if (heap_item.last_res !== want.last_res)
						report_mismatch($sformatf("last_res %b, expected %b",
							heap_item.last_res, want.last_res));
					if (heap_item.overflow !== want.overflow)
						report_mismatch($sformatf("overflow %b, expected %b",
							heap_item.overflow, want.overflow));
				end
			end

			if (start && !busy) begin
				if (keys_held < HEAP_DEPTH) begin
					shadow_keys[keys_held] = key_item.key;
					keys_held++;
				end else begin
					keys_dropped = 1'b1;
				end

				if (key_item.last) begin
					// Heap position p lives at index p-1; sift every inner node down.
					for (node = keys_held / 2; node >= 1; node--) begin
						pos     = node;
						settled = 1'b0;
						while (!settled) begin
							big = pos;
							if (2 * pos <= keys_held &&
							    shadow_keys[2 * pos - 1] > shadow_keys[big - 1])
								big = 2 * pos;
							// A tie keeps the left child.
							if (2 * pos + 1 <= keys_held &&
							    shadow_keys[2 * pos] > shadow_keys[big - 1])
								big = 2 * pos + 1;
							if (big == pos) begin
								settled = 1'b1;
							end else begin
								swap_key             = shadow_keys[pos - 1];
								shadow_keys[pos - 1] = shadow_keys[big - 1];
								shadow_keys[big - 1] = swap_key;
								pos                  = big;
							end
						end
					end

					for (int i = 0; i < keys_held; i++)
						heap_due_q.push_back('{key_res:  shadow_keys[i],
						                       last_res: (i == keys_held - 1),
						                       overflow: keys_dropped});

					keys_held    = 0;
					keys_dropped = 1'b0;
				end
			end
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap builder testbench
// Streams key sets into the heap builder, from single keys up to sets that
// overrun the store, and lets the heap order checker judge every result beat.
// ----------------------------------------------------------------------------
module tb_top;
	import mhb_pkg::*;

	// The longest quiet stretch of a correct run is the build of a full store:
	// 32 inner nodes, each sinking at most six levels. The limit leaves a wide
	// margin over that build.
	localparam int IDLE_LIMIT = 4000;
	// Stimulus stops once about this many key beats have gone in.
	localparam int KEY_TARGET = 520;
	// Cycles allowed after the last expected beat for any stray result.
	localparam int TAIL_CYCLES = 40;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_beat_t  key_item = '0;
	logic      strobe;
	out_beat_t heap_item;

	int mismatches;
	int heap_beats_due;
	int idle_cycles = 0;
	int keys_sent = 0;
	int burst_left = 0;

	always #5 clk = ~clk;

	max_heap_builder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.key_item  (key_item),
		.strobe    (strobe),
		.heap_item (heap_item)
	);

	heap_order_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.key_item       (key_item),
		.strobe         (strobe),
		.heap_item      (heap_item),
		.mismatches     (mismatches),
		.heap_beats_due (heap_beats_due)
	);

	// A cycle counts as progress when a key beat is taken or a result beat is
	// shown. Anything else, for too long, means the block has hung.
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// Offers one key beat and holds it until the block takes it. The sender
	// works in bursts: once a burst is used up, start drops for a random gap.
	// Now and then a long burst runs with no gaps at all. Since start is only
	// lowered after acceptance and raised again in a later step, it never sees
	// two assignments in the same step.
	task automatic send_key(input key_t k, input logic fin);
		start    <= 1'b1;
		key_item <= '{key: k, last: fin};
		do @(posedge clk); while (busy !== 1'b0);
		keys_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(0, 12);
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Sends a whole set; the final key carries last and closes it.
	task automatic send_list(input key_t keys []);
		foreach (keys[i])
			send_key(keys[i], i == keys.size() - 1);
	endtask

	// Key flavors: full-range random words, a narrow band that forces many
	// ties, and the signed extremes with their neighbors around zero.
	function automatic key_t pick_key(input int flavor);
		case (flavor)
			0: return key_t'($urandom);
			1: return key_t'(int'($urandom_range(0, 6)) - 3);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 32'sh0000_0000;
					default: return -32'sd1;
				endcase
			end
		endcase
	endfunction

	// Random set of n keys. A set longer than the store ends on a dropped key,
	// which must still close the set and mark every result with overflow.
	task automatic send_random_set(input int n);
		int flavor_roll;
		int flavor;
		flavor_roll = $urandom_range(0, 9);
		flavor      = (flavor_roll < 6) ? 0 : (flavor_roll < 9) ? 1 : 2;
		for (int i = 0; i < n; i++)
			send_key(pick_key(flavor), i == n - 1);
	endtask

	initial begin
		int size_roll;
		int set_size;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets. A single most-negative key is a one-node heap.
		send_list('{32'sh8000_0000});
		// The extremes in the wrong order: the root must swap with its only child.
		send_list('{32'sh8000_0000, 32'sh7FFF_FFFF});
		// Equal children: the left one moves up.
		send_list('{32'sd0, 32'sd5, 32'sd5});
		// Ascending keys sink all the way down from the root.
		send_list('{-32'sd3, -32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2, 32'sd3});
		// Already a heap: nothing should move.
		send_list('{32'sd100, 32'sd50, 32'sd40, -32'sd1, -32'sd2});
		// Sign boundaries mixed in one set.
		send_list('{32'sh8000_0000, -32'sd1, 32'sh7FFF_FFFF, 32'sd0});

		// Random part. It opens with an overrun set and a set that fills the
		// store exactly, so both limits are seen on every seed.
		send_random_set($urandom_range(65, 72));
		send_random_set(HEAP_DEPTH);
		while (keys_sent < KEY_TARGET) begin
			size_roll = $urandom_range(0, 99);
			if (size_roll < 62)
				set_size = $urandom_range(1, 10);
			else if (size_roll < 82)
				set_size = $urandom_range(11, 40);
			else if (size_roll < 91)
				set_size = $urandom_range(HEAP_DEPTH - 2, HEAP_DEPTH);
			else
				set_size = $urandom_range(HEAP_DEPTH + 1, HEAP_DEPTH + 8);
			send_random_set(set_size);
		end

		// Drain: the last set's results are queued by now; wait for all of
		// them, then leave room for any beat the block should not send.
		start <= 1'b0;
		@(posedge clk);
		while (heap_beats_due != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
